FILE: sv/crcfg_pkg.sv
// Shared types, codes and the CRC-32 byte update for the CRC frame generator/checker.
`default_nettype none

package crcfg_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // result word kinds as seen on the output port
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_CRC     = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  // work handed from front to back
  typedef enum logic [1:0] {
    TASK_ECHO      = 2'd0,
    TASK_ECHO_LAST = 2'd1,
    TASK_VERDICT   = 2'd2
  } task_kind_t;

  typedef struct packed {
    task_kind_t  kind;
    logic [7:0]  data;
    logic [31:0] crc;
    logic        match;
    logic        short_frame;
  } task_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [7:0]  out_byte;
    logic [31:0] crc_value;
    logic        crc_match;
    logic        short_frame;
    logic        run_last;
  } result_t;

  // reflected CRC-32 update by one byte, one polynomial step per bit
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] t;
    t = {24'd0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      t = (t >> 1) ^ (t[0] ? CRC_POLY : 32'd0);
    end
    return (crc >> 8) ^ t;
  endfunction

endpackage

`default_nettype wire

FILE: sv/crcfg_front.sv
// Front end: accept bytes, track frame CRC and trailer window, issue tasks.
`default_nettype none

module crcfg_front
  import crcfg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        check_mode,
  input  wire logic        accept,
  input  wire logic [7:0]  data_byte,
  input  wire logic        frame_end,
  output logic             task_push,
  output task_t            task_word
);

  logic [31:0] crc_r, crc_nxt;
  logic [31:0] window_r, window_nxt;
  logic [2:0]  seen_r, seen_nxt;

  logic [31:0] crc_upd;
  logic [31:0] window_new;
  logic        short_f;

  always_comb begin
    crc_nxt    = crc_r;
    window_nxt = window_r;
    seen_nxt   = seen_r;
    task_push  = 1'b0;
    task_word  = '0;
    short_f    = (seen_r < 3'd4);
    window_new = {window_r[23:0], data_byte};
    if (!check_mode) begin
      crc_upd = crc_byte(crc_r, data_byte);
    end else if (!short_f) begin
      crc_upd = crc_byte(crc_r, window_r[31:24]);
    end else begin
      crc_upd = crc_r;
    end

    if (accept) begin
      if (!check_mode) begin
        task_push      = 1'b1;
        task_word.data = data_byte;
        if (frame_end) begin
          task_word.kind = TASK_ECHO_LAST;
          task_word.crc  = ~crc_upd;
        end else begin
          task_word.kind = TASK_ECHO;
        end
        crc_nxt = crc_upd;
      end else begin
        crc_nxt    = crc_upd;
        window_nxt = window_new;
        if (short_f) begin
          seen_nxt = seen_r + 3'd1;
        end
        if (frame_end) begin
          task_push             = 1'b1;
          task_word.kind        = TASK_VERDICT;
          task_word.crc         = ~crc_upd;
          task_word.short_frame = short_f;
          task_word.match       = !short_f && (~crc_upd == window_new);
        end
      end
      // drop all frame state at the frame end
      if (frame_end) begin
        crc_nxt    = CRC_INIT;
        window_nxt = '0;
        seen_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= CRC_INIT;
      window_r <= '0;
      seen_r   <= '0;
    end else begin
      crc_r    <= crc_nxt;
      window_r <= window_nxt;
      seen_r   <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/crcfg_queue.sv
// Short task queue between front and back ends.
`default_nettype none

module crcfg_queue
  import crcfg_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire task_t din,
  output logic       full,
  input  wire logic  pop,
  output task_t      dout,
  output logic       empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  task_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/crcfg_back.sv
// Back end: expand tasks into result words and hold them in the output register.
`default_nettype none

module crcfg_back
  import crcfg_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_empty,
  input  wire task_t q_word,
  output logic       q_pop,
  output logic       out_vld,
  output result_t    out_word,
  input  wire logic  out_pop
);

  logic        vld_r, vld_nxt;
  result_t     res_r, res_nxt;
  logic [2:0]  rem_r, rem_nxt;
  logic [31:0] hold_r, hold_nxt;
  logic        load;

  assign out_vld  = vld_r;
  assign out_word = res_r;
  assign load     = !vld_r || out_pop;

  always_comb begin
    vld_nxt  = vld_r;
    res_nxt  = res_r;
    rem_nxt  = rem_r;
    hold_nxt = hold_r;
    q_pop    = 1'b0;
    if (load) begin
      if (rem_r != 3'd0) begin
        // emit trailing CRC bytes, most significant first
        vld_nxt           = 1'b1;
        res_nxt           = '0;
        res_nxt.item_kind = KIND_CRC;
        res_nxt.crc_value = hold_r;
        res_nxt.run_last  = (rem_r == 3'd1);
        case (rem_r)
          3'd4:    res_nxt.out_byte = hold_r[31:24];
          3'd3:    res_nxt.out_byte = hold_r[23:16];
          3'd2:    res_nxt.out_byte = hold_r[15:8];
          default: res_nxt.out_byte = hold_r[7:0];
        endcase
        rem_nxt = rem_r - 3'd1;
      end else if (!q_empty) begin
        q_pop   = 1'b1;
        vld_nxt = 1'b1;
        res_nxt = '0;
        case (q_word.kind)
          TASK_ECHO: begin
            res_nxt.item_kind = KIND_DATA;
            res_nxt.out_byte  = q_word.data;
            res_nxt.run_last  = 1'b1;
          end
          TASK_ECHO_LAST: begin
            res_nxt.item_kind = KIND_DATA;
            res_nxt.out_byte  = q_word.data;
            res_nxt.crc_value = q_word.crc;
            rem_nxt           = 3'd4;
            hold_nxt          = q_word.crc;
          end
          default: begin
            res_nxt.item_kind   = KIND_VERDICT;
            res_nxt.crc_value   = q_word.crc;
            res_nxt.crc_match   = q_word.match;
            res_nxt.short_frame = q_word.short_frame;
            res_nxt.run_last    = 1'b1;
          end
        endcase
      end else begin
        vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    hold_r <= hold_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      rem_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/crc32_frame_generate_check.sv
// Top level of the CRC-32 frame generator/checker.
// Byte-stream CRC-32 (reflected poly 0xEDB88320, init all ones, final inversion). Each input
// word is one byte plus a frame-end flag. With cfg check_mode = 0 every byte is echoed, and
// after the last byte the four CRC bytes follow, most significant first (the echo of the last
// byte and the CRC bytes carry the final CRC in crc_value). With check_mode = 1 the last four
// bytes are treated as a big-endian CRC trailer; one verdict word comes out per frame, with
// crc_match and short_frame (frames under five bytes). Input takes one byte per clock while
// full is low; the front end updates the CRC in the same cycle. The back end emits one result
// word per clock while the output is popped, so a generate-mode frame end yields five result
// words; the task queue (QUEUE_DEPTH) absorbs that burst and output stalls, and full only
// rises when it fills. The first result word of a byte passes through the task queue and then
// the output register before it shows on the output. Write cfg only while the block is idle.
`default_nettype none

module crc32_frame_generate_check
  import crcfg_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  // input word channel
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_frame_end,
  // result word channel
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       out_item_kind,
  output logic [7:0]       out_out_byte,
  output logic [31:0]      out_crc_value,
  output logic             out_crc_match,
  output logic             out_short_frame,
  output logic             out_run_last
);

  logic    mode_r, mode_nxt;
  logic    in_accept;
  logic    task_push;
  task_t   task_word;
  logic    q_full, q_empty, q_pop;
  task_t   q_word;
  logic    out_vld;
  result_t out_word;

  // hold the mode between writes
  assign mode_nxt = cfg_wr_en ? cfg_wr_data : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // stall the input whenever the queue cannot take another task
  assign full      = q_full;
  assign in_accept = push && !q_full;

  crcfg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .check_mode (mode_r),
    .accept     (in_accept),
    .data_byte  (in_data_byte),
    .frame_end  (in_frame_end),
    .task_push  (task_push),
    .task_word  (task_word)
  );

  crcfg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (task_push),
    .din   (task_word),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_word),
    .empty (q_empty)
  );

  crcfg_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_word   (q_word),
    .q_pop    (q_pop),
    .out_vld  (out_vld),
    .out_word (out_word),
    .out_pop  (pop)
  );

  // drive the result word straight from the output register
  assign empty           = !out_vld;
  assign out_item_kind   = out_word.item_kind;
  assign out_out_byte    = out_word.out_byte;
  assign out_crc_value   = out_word.crc_value;
  assign out_crc_match   = out_word.crc_match;
  assign out_short_frame = out_word.short_frame;
  assign out_run_last    = out_word.run_last;

endmodule

`default_nettype wire
